// ===== design/bzc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_pkg: shared definitions for the bilinear zoom crop unit
// Default sizes, widths, register map, reset values, command codes and queue depth.
// ----------------------------------------------------------------------------
package bzc_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int MAX_SCALE_DEF  = 8;

	localparam int PIX_W   = 8;
	localparam int SCALE_W = 4;
	localparam int DIM_W   = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_SCALE  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd3;
	localparam logic [DIM_W-1:0]   DIM_RST   = 10'd512;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// ===== design/bilinear_zoom_crop_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_zoom_crop_unit: centred crop and bilinear integer zoom
// Loads a grayscale frame, then produces the enlarged centre of it.
// ----------------------------------------------------------------------------
// Usage. A command transfer happens at a rising edge with start high and busy
// low. With cmd low, pixel_in is stored as the next source pixel in raster
// order; with cmd high, the next output pixel is requested. Each request
// yields one transfer on pixel_out and frame_last, marked by done for exactly
// one cycle; the receiver cannot stall it, so it must take every strobe.
// frame_last is high on the last pixel of the output frame.
// Timing. The front end stays busy while a command sits in its second stage,
// where the anchor row address multiply is done, so it cannot take a new
// command while it holds one. A load is written to the single-port frame
// memory as the back end pops it, without leaving the idle state. An output
// pixel takes the back end through four memory reads for the anchors, then a
// horizontal and a vertical blend, each with a divide by the scale, in states
// R0 to R4, MUL1, DIV1, MUL2 and DIV2; done rises in state OUT. A four-entry
// queue lets commands be taken while a pixel is worked.
// Reset and configuration. After reset, and after every write to a mapped
// register, busy stays high while the crop geometry is recomputed; such a
// write also rewinds the load and output positions. The frame memory is left
// untouched and needs no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_zoom_crop_unit #(
	parameter int MAX_WIDTH  = bzc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bzc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_SCALE  = bzc_pkg::MAX_SCALE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic [bzc_pkg::PIX_W-1:0]    pixel_in,
	output logic                         done,
	output logic [bzc_pkg::PIX_W-1:0]    pixel_out,
	output logic                         frame_last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bzc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bzc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bzc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import bzc_pkg::*;

	localparam int SW   = $clog2(MAX_SCALE + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CW1  = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int RW1  = $clog2(MAX_HEIGHT + 1);
	localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int AW1  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int PMAX = ((1 << PIX_W) - 1) * MAX_SCALE;
	localparam int DMAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int NMAX = (PMAX > DMAX) ? PMAX : DMAX;
	localparam int NW   = $clog2(NMAX + 1);

	logic [SCALE_W-1:0] scale_q;
	logic [DIM_W-1:0]   width_q, height_q;
	logic               wr, clr;
	logic [1:0]         idx;
	logic [SW-1:0]      eff_s;
	logic [CW1-1:0]     eff_w;
	logic [RW1-1:0]     eff_h;

	logic             q_full, push, push_kind, push_last;
	logic [PIX_W-1:0] push_pix;
	logic [AW-1:0]    push_base0, push_base1;
	logic [CW-1:0]    push_c0, push_c1;
	logic [SW-1:0]    push_fx, push_fy;

	// Register file. A write to an unmapped index changes nothing.
	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite & pready;
	assign clr    = wr && (idx == REG_SCALE || idx == REG_WIDTH || idx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
		end else if (wr) begin
			case (idx)
				REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCALE:  prdata = PDATA_W'(scale_q);
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Out-of-range settings act as the nearest legal value.
	always_comb begin
		if (scale_q == '0) begin
			eff_s = SW'(1);
		end else if (int'(scale_q) > MAX_SCALE) begin
			eff_s = SW'(MAX_SCALE);
		end else begin
			eff_s = SW'(scale_q);
		end
		if (width_q == '0) begin
			eff_w = CW1'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = CW1'(MAX_WIDTH);
		end else begin
			eff_w = CW1'(width_q);
		end
		if (height_q == '0) begin
			eff_h = RW1'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = RW1'(MAX_HEIGHT);
		end else begin
			eff_h = RW1'(height_q);
		end
	end

	bzc_front #(
		.SW(SW), .CW(CW), .CW1(CW1), .RW(RW), .RW1(RW1),
		.AW(AW), .AW1(AW1), .NW(NW), .MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .pixel_in(pixel_in),
		.busy(busy), .clr(clr), .eff_s(eff_s), .eff_w(eff_w), .eff_h(eff_h),
		.q_full(q_full), .push(push), .push_kind(push_kind), .push_pix(push_pix),
		.push_base0(push_base0), .push_base1(push_base1),
		.push_c0(push_c0), .push_c1(push_c1),
		.push_fx(push_fx), .push_fy(push_fy), .push_last(push_last)
	);

	bzc_back #(
		.SW(SW), .CW(CW), .AW(AW), .NW(NW), .MAX_SCALE(MAX_SCALE)
	) u_back (
		.clk(clk), .arst_n(arst_n), .push(push), .push_kind(push_kind),
		.push_pix(push_pix), .push_base0(push_base0), .push_base1(push_base1),
		.push_c0(push_c0), .push_c1(push_c1), .push_fx(push_fx), .push_fy(push_fy),
		.push_last(push_last), .eff_s(eff_s), .q_full(q_full), .done(done),
		.pixel_out(pixel_out), .frame_last(frame_last)
	);

endmodule
`default_nettype wire

// ===== design/bzc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bzc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== design/bzc_sdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_sdiv: divide by the scale factor
// Multiplies by a rounded-up reciprocal from a constant table; the quotient
// is exact for every numerator that fits NW bits. The quotient is registered.
// ----------------------------------------------------------------------------
module bzc_sdiv #(
	parameter int NW        = 12,
	parameter int SW        = 4,
	parameter int MAX_SCALE = 8
) (
	input  logic          clk,
	input  logic [NW-1:0] n,
	input  logic [SW-1:0] s,
	output logic [NW-1:0] q
);

	localparam int K  = NW + SW;
	localparam int PW = NW + K + 1;

	logic [K:0]    recip [MAX_SCALE+1];
	logic [PW-1:0] prod;
	logic [NW-1:0] q_q;

	assign recip[0] = '0;
	for (genvar g = 1; g <= MAX_SCALE; g++) begin : g_recip
		localparam longint unsigned RV = ((64'd1 << K) + g - 1) / g;
		assign recip[g] = (K+1)'(RV);
	end

	assign prod = PW'(n) * PW'(recip[s]);

	always_ff @(posedge clk) begin
		q_q <= prod[K +: NW];
	end

	assign q = q_q;

endmodule
`default_nettype wire

// ===== design/bzc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_front: command intake and anchor addressing
// Tracks load and output positions, derives crop geometry after each
// configuration change and pushes work entries into the back end's queue.
// ----------------------------------------------------------------------------
module bzc_front #(
	parameter int SW = 4,
	parameter int CW = 9,
	parameter int CW1 = 10,
	parameter int RW = 9,
	parameter int RW1 = 10,
	parameter int AW = 18,
	parameter int AW1 = 19,
	parameter int NW = 12,
	parameter int MAX_SCALE = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     cmd,
	input  logic [bzc_pkg::PIX_W-1:0] pixel_in,
	output logic                     busy,
	input  logic                     clr,
	input  logic [SW-1:0]            eff_s,
	input  logic [CW1-1:0]           eff_w,
	input  logic [RW1-1:0]           eff_h,
	input  logic                     q_full,
	output logic                     push,
	output logic                     push_kind,
	output logic [bzc_pkg::PIX_W-1:0] push_pix,
	output logic [AW-1:0]            push_base0,
	output logic [AW-1:0]            push_base1,
	output logic [CW-1:0]            push_c0,
	output logic [CW-1:0]            push_c1,
	output logic [SW-1:0]            push_fx,
	output logic [SW-1:0]            push_fy,
	output logic                     push_last
);
	import bzc_pkg::*;

	logic          prep_q;
	logic [2:0]    ps_q;
	logic [NW-1:0] dn, dq;
	logic [CW-1:0] lastx_q, startcol_q;
	logic [RW-1:0] lasty_q, startrow_q;
	logic [AW1-1:0] total_q;

	logic [CW-1:0] x_q, cx_q;
	logic [RW-1:0] y_q, cy_q;
	logic [SW-1:0] fx_q, fy_q;
	logic [AW-1:0] load_q;
	logic          v1_q;

	logic          kind_s1, last_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0] la_s1;
	logic [RW-1:0] r0_s1, r1_s1;
	logic [CW-1:0] c0_s1, c1_s1;
	logic [SW-1:0] fx_s1, fy_s1;

	logic          accept;
	logic [CW-1:0] wm1, c0, c1;
	logic [RW-1:0] hm1, r0, r1;
	logic [CW:0]   cx1w, c0w, c1w;
	logic [RW:0]   cy1w, r0w, r1w;
	logic [CW-1:0] cx1;
	logic [RW-1:0] cy1;
	logic          last;

	bzc_sdiv #(.NW(NW), .SW(SW), .MAX_SCALE(MAX_SCALE)) u_sdiv (
		.clk(clk), .n(dn), .s(eff_s), .q(dq)
	);

	// Geometry divisions share one divider, one per cycle.
	always_comb begin
		case (ps_q)
			3'd0:    dn = NW'(eff_w - 1'b1);
			3'd1:    dn = NW'(eff_h - 1'b1);
			3'd2:    dn = NW'(eff_w >> 1);
			default: dn = NW'(eff_h >> 1);
		endcase
	end

	assign busy   = prep_q | v1_q | q_full;
	assign accept = start & ~busy;

	assign wm1 = CW'(eff_w - 1'b1);
	assign hm1 = RW'(eff_h - 1'b1);

	always_comb begin
		cx1w = (CW+1)'(cx_q) + 1'b1;
		cy1w = (RW+1)'(cy_q) + 1'b1;
		cx1  = (cx1w > (CW+1)'(lastx_q)) ? lastx_q : CW'(cx1w);
		cy1  = (cy1w > (RW+1)'(lasty_q)) ? lasty_q : RW'(cy1w);
		c0w  = (CW+1)'(cx_q) + (CW+1)'(startcol_q);
		c1w  = (CW+1)'(cx1) + (CW+1)'(startcol_q);
		r0w  = (RW+1)'(cy_q) + (RW+1)'(startrow_q);
		r1w  = (RW+1)'(cy1) + (RW+1)'(startrow_q);
		c0   = (c0w >= (CW+1)'(eff_w)) ? wm1 : CW'(c0w);
		c1   = (c1w >= (CW+1)'(eff_w)) ? wm1 : CW'(c1w);
		r0   = (r0w >= (RW+1)'(eff_h)) ? hm1 : RW'(r0w);
		r1   = (r1w >= (RW+1)'(eff_h)) ? hm1 : RW'(r1w);
		last = (y_q == hm1) && (x_q == wm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q <= 1'b1;
			ps_q   <= '0;
			x_q    <= '0;
			cx_q   <= '0;
			fx_q   <= '0;
			y_q    <= '0;
			cy_q   <= '0;
			fy_q   <= '0;
			load_q <= '0;
			v1_q   <= 1'b0;
		end else if (clr) begin
			prep_q <= 1'b1;
			ps_q   <= '0;
			x_q    <= '0;
			cx_q   <= '0;
			fx_q   <= '0;
			y_q    <= '0;
			cy_q   <= '0;
			fy_q   <= '0;
			load_q <= '0;
			v1_q   <= 1'b0;
		end else begin
			v1_q <= accept;
			if (prep_q) begin
				ps_q <= ps_q + 1'b1;
				if (ps_q == 3'd4) begin
					prep_q <= 1'b0;
				end
			end
			if (accept && cmd == CMD_LOAD) begin
				if (AW1'(load_q) + 1'b1 >= total_q) begin
					load_q <= '0;
				end else begin
					load_q <= load_q + 1'b1;
				end
			end
			if (accept && cmd == CMD_PIXEL) begin
				if ((CW+1)'(x_q) + 1'b1 >= (CW+1)'(eff_w)) begin
					x_q  <= '0;
					cx_q <= '0;
					fx_q <= '0;
					if ((RW+1)'(y_q) + 1'b1 >= (RW+1)'(eff_h)) begin
						y_q  <= '0;
						cy_q <= '0;
						fy_q <= '0;
					end else begin
						y_q <= y_q + 1'b1;
						if (fy_q + 1'b1 >= eff_s) begin
							fy_q <= '0;
							cy_q <= cy_q + 1'b1;
						end else begin
							fy_q <= fy_q + 1'b1;
						end
					end
				end else begin
					x_q <= x_q + 1'b1;
					if (fx_q + 1'b1 >= eff_s) begin
						fx_q <= '0;
						cx_q <= cx_q + 1'b1;
					end else begin
						fx_q <= fx_q + 1'b1;
					end
				end
			end
		end
	end

	// Geometry results and the stage one payload.
	always_ff @(posedge clk) begin
		if (prep_q) begin
			case (ps_q)
				3'd1:    lastx_q <= CW'(dq);
				3'd2:    lasty_q <= RW'(dq);
				3'd3:    startcol_q <= CW'(eff_w >> 1) - CW'(dq);
				3'd4:    startrow_q <= RW'(eff_h >> 1) - RW'(dq);
				default: total_q <= AW1'(AW1'(eff_w) * AW1'(eff_h));
			endcase
		end
		if (accept) begin
			kind_s1 <= cmd;
			pix_s1  <= pixel_in;
			la_s1   <= load_q;
			r0_s1   <= r0;
			r1_s1   <= r1;
			c0_s1   <= c0;
			c1_s1   <= c1;
			fx_s1   <= fx_q;
			fy_s1   <= fy_q;
			last_s1 <= last;
		end
	end

	assign push       = v1_q;
	assign push_kind  = kind_s1;
	assign push_pix   = pix_s1;
	assign push_base0 = (kind_s1 == CMD_PIXEL) ? AW'(AW'(r0_s1) * AW'(eff_w)) : la_s1;
	assign push_base1 = AW'(AW'(r1_s1) * AW'(eff_w));
	assign push_c0    = c0_s1;
	assign push_c1    = c1_s1;
	assign push_fx    = fx_s1;
	assign push_fy    = fy_s1;
	assign push_last  = last_s1;

endmodule
`default_nettype wire

// ===== design/bzc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_back: work queue, frame memory and interpolation
// Stores loaded pixels and, for each output request, reads four anchors
// and blends them horizontally and then vertically.
// ----------------------------------------------------------------------------
module bzc_back #(
	parameter int SW = 4,
	parameter int CW = 9,
	parameter int AW = 18,
	parameter int NW = 12,
	parameter int MAX_SCALE = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     push_kind,
	input  logic [bzc_pkg::PIX_W-1:0] push_pix,
	input  logic [AW-1:0]            push_base0,
	input  logic [AW-1:0]            push_base1,
	input  logic [CW-1:0]            push_c0,
	input  logic [CW-1:0]            push_c1,
	input  logic [SW-1:0]            push_fx,
	input  logic [SW-1:0]            push_fy,
	input  logic                     push_last,
	input  logic [SW-1:0]            eff_s,
	output logic                     q_full,
	output logic                     done,
	output logic [bzc_pkg::PIX_W-1:0] pixel_out,
	output logic                     frame_last
);
	import bzc_pkg::*;

	localparam int QIW = $clog2(QUEUE_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_R0   = 4'd1;
	localparam logic [3:0] ST_R1   = 4'd2;
	localparam logic [3:0] ST_R2   = 4'd3;
	localparam logic [3:0] ST_R3   = 4'd4;
	localparam logic [3:0] ST_R4   = 4'd5;
	localparam logic [3:0] ST_MUL1 = 4'd6;
	localparam logic [3:0] ST_DIV1 = 4'd7;
	localparam logic [3:0] ST_MUL2 = 4'd8;
	localparam logic [3:0] ST_DIV2 = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic             kind_m [QUEUE_DEPTH];
	logic [PIX_W-1:0] pix_m  [QUEUE_DEPTH];
	logic [AW-1:0]    b0_m   [QUEUE_DEPTH];
	logic [AW-1:0]    b1_m   [QUEUE_DEPTH];
	logic [CW-1:0]    c0_m   [QUEUE_DEPTH];
	logic [CW-1:0]    c1_m   [QUEUE_DEPTH];
	logic [SW-1:0]    fx_m   [QUEUE_DEPTH];
	logic [SW-1:0]    fy_m   [QUEUE_DEPTH];
	logic             last_m [QUEUE_DEPTH];

	logic [QIW-1:0] wp_q, rp_q;
	logic [QIW:0]   cnt_q;
	logic [3:0]     st_q;
	logic           pop;

	logic [AW-1:0]  b0_q, b1_q;
	logic [CW-1:0]  c0_q, c1_q;
	logic [SW-1:0]  fx_q, fy_q;
	logic           last_q;
	logic [PIX_W-1:0] a_q, b_q, c_q, d_q;
	logic [NW-1:0]  ne_q, nf_q, nx_q;

	logic           we;
	logic [AW-1:0]  addr;
	logic [PIX_W-1:0] rdata;
	logic [NW-1:0]  dn0, dq0, dq1;
	logic [SW-1:0]  wx, wy;

	assign q_full = (cnt_q == (QIW+1)'(QUEUE_DEPTH));
	assign pop    = (st_q == ST_IDLE) && (cnt_q != '0);
	assign we     = pop && (kind_m[rp_q] == CMD_LOAD);

	always_comb begin
		case (st_q)
			ST_R0:   addr = b0_q + AW'(c0_q);
			ST_R1:   addr = b0_q + AW'(c1_q);
			ST_R2:   addr = b1_q + AW'(c0_q);
			ST_R3:   addr = b1_q + AW'(c1_q);
			default: addr = b0_m[rp_q];
		endcase
	end

	bzc_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(pix_m[rp_q]), .rdata(rdata)
	);

	assign dn0 = (st_q == ST_DIV2) ? nx_q : ne_q;

	bzc_sdiv #(.NW(NW), .SW(SW), .MAX_SCALE(MAX_SCALE)) u_div0 (
		.clk(clk), .n(dn0), .s(eff_s), .q(dq0)
	);
	bzc_sdiv #(.NW(NW), .SW(SW), .MAX_SCALE(MAX_SCALE)) u_div1 (
		.clk(clk), .n(nf_q), .s(eff_s), .q(dq1)
	);

	assign wx = eff_s - fx_q;
	assign wy = eff_s - fy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			st_q  <= ST_IDLE;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop && kind_m[rp_q] == CMD_PIXEL) begin
						st_q <= ST_R0;
					end
				end
				ST_R0:   st_q <= ST_R1;
				ST_R1:   st_q <= ST_R2;
				ST_R2:   st_q <= ST_R3;
				ST_R3:   st_q <= ST_R4;
				ST_R4:   st_q <= ST_MUL1;
				ST_MUL1: st_q <= ST_DIV1;
				ST_DIV1: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_DIV2;
				ST_DIV2: st_q <= ST_OUT;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_m[wp_q] <= push_kind;
			pix_m[wp_q]  <= push_pix;
			b0_m[wp_q]   <= push_base0;
			b1_m[wp_q]   <= push_base1;
			c0_m[wp_q]   <= push_c0;
			c1_m[wp_q]   <= push_c1;
			fx_m[wp_q]   <= push_fx;
			fy_m[wp_q]   <= push_fy;
			last_m[wp_q] <= push_last;
		end
		if (pop) begin
			b0_q   <= b0_m[rp_q];
			b1_q   <= b1_m[rp_q];
			c0_q   <= c0_m[rp_q];
			c1_q   <= c1_m[rp_q];
			fx_q   <= fx_m[rp_q];
			fy_q   <= fy_m[rp_q];
			last_q <= last_m[rp_q];
		end
		case (st_q)
			ST_R1: a_q <= rdata;
			ST_R2: b_q <= rdata;
			ST_R3: c_q <= rdata;
			ST_R4: d_q <= rdata;
			ST_MUL1: begin
				ne_q <= NW'(NW'(a_q) * NW'(wx)) + NW'(NW'(b_q) * NW'(fx_q));
				nf_q <= NW'(NW'(c_q) * NW'(wx)) + NW'(NW'(d_q) * NW'(fx_q));
			end
			ST_MUL2: nx_q <= NW'(dq0 * NW'(wy)) + NW'(dq1 * NW'(fy_q));
			default: ;
		endcase
	end

	assign done       = (st_q == ST_OUT);
	assign pixel_out  = PIX_W'(dq0);
	assign frame_last = last_q;

endmodule
`default_nettype wire
